// ----- rtl/blt_pkg.sv -----
package blt_pkg;

    localparam int MAX_LINE = 256;
    localparam logic [8:0] MAX_COL = 9'(MAX_LINE);
    localparam int KW_COUNT = 69;

    typedef enum logic [3:0] {
        M_IDLE, M_LINENUM, M_INT, M_FRAC, M_DOT, M_IDENT, M_STRING, M_REM, M_LT, M_GT
    } mode_t;

    localparam logic [6:0] K_LINENUM = 7'd0;
    localparam logic [6:0] K_NUMBER  = 7'd1;
    localparam logic [6:0] K_IDENT   = 7'd2;
    localparam logic [6:0] K_STRING  = 7'd3;
    localparam logic [6:0] K_EOL     = 7'd4;
    localparam logic [6:0] K_COMMA   = 7'd5;
    localparam logic [6:0] K_COLON   = 7'd6;
    localparam logic [6:0] K_SEMI    = 7'd7;
    localparam logic [6:0] K_MINUS   = 7'd8;
    localparam logic [6:0] K_LPAREN  = 7'd9;
    localparam logic [6:0] K_RPAREN  = 7'd10;
    localparam logic [6:0] K_PLUS    = 7'd11;
    localparam logic [6:0] K_STAR    = 7'd12;
    localparam logic [6:0] K_SLASH   = 7'd13;
    localparam logic [6:0] K_HASH    = 7'd14;
    localparam logic [6:0] K_EQ      = 7'd15;
    localparam logic [6:0] K_LT      = 7'd16;
    localparam logic [6:0] K_GT      = 7'd17;
    localparam logic [6:0] K_NE      = 7'd18;
    localparam logic [6:0] K_LE      = 7'd19;
    localparam logic [6:0] K_GE      = 7'd20;
    localparam logic [6:0] K_KW0     = 7'd21;
    localparam logic [6:0] K_REM     = 7'd61;
    localparam logic [6:0] K_LAST    = 7'd89;

    localparam logic [1:0] E_NONE   = 2'd0;
    localparam logic [1:0] E_STRING = 2'd1;
    localparam logic [1:0] E_CHAR   = 2'd2;
    localparam logic [1:0] E_LONG   = 2'd3;

    typedef struct packed {
        logic [6:0] kind;
        logic [8:0] col;
        logic [8:0] len;
        logic [1:0] err;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       r0;
        res_t       r1;
    } push_t;

    // right-aligned, zero padded: matches a word buffer that shifts in from the right
    localparam logic [55:0] KW_TABLE [KW_COUNT] = '{
        "PRINT", "USING", "OPEN", "CLOSE", "WRITE", "LINE", "AS", "LET",
        "INPUT", "OUTPUT", "APPEND", "RANDOM", "LEN", "IF", "AND", "OR", "NOT",
        "THEN", "ELSE", "GOTO", "GOSUB", "RETURN", "FOR", "TO", "STEP", "NEXT",
        "DATA", "READ", "RESTORE", "DIM", "WHILE", "WEND", "ON", "DEFINT",
        "DEFSTR", "DEFSNG", "DEFDBL", "STOP", "CONT", "END", "REM", "LIST",
        "RUN", "NEW", "CLEAR", "FIELD", "GET", "PUT", "LSET", "RSET", "KILL",
        "NAME", "MKDIR", "RMDIR", "CLS", "LOCATE", "COLOR", "BEEP", "SCREEN",
        "KEY", "SOUND", "PLAY", "PSET", "CIRCLE", "PAINT", "DRAW", "VIEW",
        "WINDOW", "PALETTE"
    };

    function automatic logic [6:0] word_kind(input logic [55:0] w, input logic [3:0] n);
        logic [6:0] k;
        k = K_IDENT;
        if (n <= 4'd7)
        begin
            for (int i = 0; i < KW_COUNT; i++)
            begin
                if (w == KW_TABLE[i])
                begin
                    k = K_KW0 + 7'(i);
                end
            end
        end
        return k;
    endfunction

endpackage

// ----- rtl/blt_in_if.sv -----
interface blt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       line_end;
    modport source (output valid, source_byte, line_end, input ready);
    modport sink (input valid, source_byte, line_end, output ready);
endinterface

// ----- rtl/blt_out_if.sv -----
interface blt_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] token_kind;
    logic [8:0] start_column;
    logic [8:0] source_length;
    logic [1:0] error_code;
    logic       run_last;
    modport source (output valid, token_kind, start_column, source_length, error_code,
                    run_last, input ready);
    modport sink (input valid, token_kind, start_column, source_length, error_code,
                  run_last, output ready);
endinterface

// ----- rtl/blt_scan.sv -----
module blt_scan
    import blt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  c,
    input  logic        line_end,
    output push_t       push
);

    mode_t       mode_reg, mode_next;
    logic        first_reg, first_next;
    logic [8:0]  col_reg, col_next;
    logic [8:0]  start_reg, start_next;
    logic [55:0] word_reg, word_next;
    logic [3:0]  wlen_reg, wlen_next;
    logic        abort_reg, abort_next;

    logic        cv, iv, run_idle;
    res_t        cr, ir;
    logic [8:0]  col, len, eol_col, eol_len;
    logic [7:0]  uc;
    logic        dig, alpha, blank, wch;

    always_comb
    begin
        col      = col_reg + 9'd1;
        len      = col - start_reg;
        eol_col  = col_reg + 9'd1;
        eol_len  = eol_col - start_reg;
        dig      = (c >= "0") && (c <= "9");
        alpha    = ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
        blank    = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
        wch      = alpha || dig || (c == "_") || (c == "$");
        uc       = ((c >= "a") && (c <= "z")) ? c - 8'd32 : c;

        mode_next  = mode_reg;
        first_next = first_reg;
        col_next   = col_reg;
        start_next = start_reg;
        word_next  = word_reg;
        wlen_next  = wlen_reg;
        abort_next = abort_reg;
        cv = 1'b0;
        iv = 1'b0;
        cr = '0;
        ir = '0;
        run_idle = 1'b0;

        if (line_end)
        begin
            if (!abort_reg)
            begin
                iv = 1'b1;
                ir = '{K_EOL, eol_col, 9'd0, E_NONE, 1'b0};
                case (mode_reg)
                    M_LINENUM: begin cv = 1'b1; cr = '{K_LINENUM, start_reg, eol_len, E_NONE, 1'b0}; end
                    M_INT, M_FRAC:
                    begin
                        cv = 1'b1;
                        cr = '{K_NUMBER, start_reg, eol_len, E_NONE, 1'b0};
                    end
                    M_DOT:
                    begin
                        iv = 1'b0;
                        cv = 1'b1;
                        cr = '{K_EOL, start_reg, 9'd0, E_CHAR, 1'b0};
                    end
                    M_IDENT:
                    begin
                        cv = 1'b1;
                        cr = '{word_kind(word_reg, wlen_reg), start_reg, eol_len, E_NONE, 1'b0};
                    end
                    M_STRING:
                    begin
                        iv = 1'b0;
                        cv = 1'b1;
                        cr = '{K_EOL, start_reg, 9'd0, E_STRING, 1'b0};
                    end
                    M_REM:
                    begin
                        cv = (eol_len != 9'd0);
                        cr = '{K_STRING, start_reg, eol_len, E_NONE, 1'b0};
                    end
                    M_LT: begin cv = 1'b1; cr = '{K_LT, start_reg, 9'd1, E_NONE, 1'b0}; end
                    M_GT: begin cv = 1'b1; cr = '{K_GT, start_reg, 9'd1, E_NONE, 1'b0}; end
                    default: cv = 1'b0;
                endcase
            end
            mode_next  = M_IDLE;
            first_next = 1'b1;
            col_next   = '0;
            start_next = '0;
            word_next  = '0;
            wlen_next  = '0;
            abort_next = 1'b0;
        end
        else if (!abort_reg)
        begin
            if (col_reg >= MAX_COL)
            begin
                cv = 1'b1;
                cr = '{K_EOL, MAX_COL + 9'd1, 9'd0, E_LONG, 1'b0};
                abort_next = 1'b1;
                mode_next  = M_IDLE;
            end
            else
            begin
                col_next = col;
                case (mode_reg)
                    M_LINENUM, M_INT:
                    begin
                        if (dig)
                        begin
                        end
                        else if ((mode_reg == M_INT) && (c == "."))
                        begin
                            mode_next = M_FRAC;
                        end
                        else
                        begin
                            cv = 1'b1;
                            cr = '{(mode_reg == M_LINENUM) ? K_LINENUM : K_NUMBER,
                                   start_reg, len, E_NONE, 1'b0};
                            run_idle = 1'b1;
                        end
                    end
                    M_FRAC:
                    begin
                        if (!dig)
                        begin
                            cv = 1'b1;
                            cr = '{K_NUMBER, start_reg, len, E_NONE, 1'b0};
                            run_idle = 1'b1;
                        end
                    end
                    M_DOT:
                    begin
                        if (dig)
                        begin
                            mode_next = M_FRAC;
                        end
                        else
                        begin
                            cv = 1'b1;
                            cr = '{K_EOL, start_reg, 9'd0, E_CHAR, 1'b0};
                            abort_next = 1'b1;
                            mode_next  = M_IDLE;
                        end
                    end
                    M_IDENT:
                    begin
                        if (wch)
                        begin
                            if (wlen_reg < 4'd7)
                            begin
                                word_next = {word_reg[47:0], uc};
                            end
                            if (wlen_reg < 4'd8)
                            begin
                                wlen_next = wlen_reg + 4'd1;
                            end
                        end
                        else
                        begin
                            cv = 1'b1;
                            cr = '{word_kind(word_reg, wlen_reg), start_reg, len, E_NONE, 1'b0};
                            if (cr.kind == K_REM)
                            begin
                                mode_next  = M_REM;
                                start_next = col;
                            end
                            else
                            begin
                                run_idle = 1'b1;
                            end
                        end
                    end
                    M_STRING:
                    begin
                        if (c == "\"")
                        begin
                            cv = 1'b1;
                            cr = '{K_STRING, start_reg, len - 9'd1, E_NONE, 1'b0};
                            mode_next = M_IDLE;
                        end
                    end
                    M_REM:
                    begin
                    end
                    M_LT:
                    begin
                        mode_next = M_IDLE;
                        cv = 1'b1;
                        if (c == ">")
                            cr = '{K_NE, start_reg, 9'd2, E_NONE, 1'b0};
                        else if (c == "=")
                            cr = '{K_LE, start_reg, 9'd2, E_NONE, 1'b0};
                        else
                        begin
                            cr = '{K_LT, start_reg, 9'd1, E_NONE, 1'b0};
                            run_idle = 1'b1;
                        end
                    end
                    M_GT:
                    begin
                        mode_next = M_IDLE;
                        cv = 1'b1;
                        if (c == "=")
                            cr = '{K_GE, start_reg, 9'd2, E_NONE, 1'b0};
                        else
                        begin
                            cr = '{K_GT, start_reg, 9'd1, E_NONE, 1'b0};
                            run_idle = 1'b1;
                        end
                    end
                    default: run_idle = 1'b1;
                endcase

                if (run_idle)
                begin
                    mode_next = M_IDLE;
                    ir = '{K_EOL, col, 9'd1, E_NONE, 1'b0};
                    if (blank)
                    begin
                    end
                    else if (dig)
                    begin
                        mode_next  = first_reg ? M_LINENUM : M_INT;
                        start_next = col;
                        first_next = 1'b0;
                    end
                    else if (c == ".")
                    begin
                        if (first_reg)
                        begin
                            iv = 1'b1;
                            ir = '{K_EOL, col, 9'd0, E_CHAR, 1'b0};
                            abort_next = 1'b1;
                        end
                        else
                        begin
                            mode_next  = M_DOT;
                            start_next = col;
                            first_next = 1'b0;
                        end
                    end
                    else if (alpha || (c == "_"))
                    begin
                        mode_next  = M_IDENT;
                        start_next = col;
                        first_next = 1'b0;
                        word_next  = {48'd0, uc};
                        wlen_next  = 4'd1;
                    end
                    else if ((c == "\"") || (c == "<") || (c == ">"))
                    begin
                        mode_next  = (c == "\"") ? M_STRING : ((c == "<") ? M_LT : M_GT);
                        start_next = col;
                        first_next = 1'b0;
                    end
                    else
                    begin
                        iv = 1'b1;
                        case (c)
                            ",":     ir.kind = K_COMMA;
                            ":":     ir.kind = K_COLON;
                            ";":     ir.kind = K_SEMI;
                            "-":     ir.kind = K_MINUS;
                            "(":     ir.kind = K_LPAREN;
                            ")":     ir.kind = K_RPAREN;
                            "+":     ir.kind = K_PLUS;
                            "*":     ir.kind = K_STAR;
                            "/":     ir.kind = K_SLASH;
                            "#":     ir.kind = K_HASH;
                            "=":     ir.kind = K_EQ;
                            default:
                            begin
                                ir.len = 9'd0;
                                ir.err = E_CHAR;
                                abort_next = 1'b1;
                            end
                        endcase
                        if (ir.err == E_NONE)
                        begin
                            first_next = 1'b0;
                        end
                    end
                end
            end
        end

        // pack results in order, mark the last one
        push = '0;
        if (cv && iv)
        begin
            push.count = 2'd2;
            push.r0 = cr;
            push.r1 = ir;
            push.r1.last = 1'b1;
        end
        else if (cv || iv)
        begin
            push.count = 2'd1;
            push.r0 = cv ? cr : ir;
            push.r0.last = 1'b1;
        end
        if (!accept)
        begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            first_reg <= 1'b1;
            col_reg   <= '0;
            start_reg <= '0;
            word_reg  <= '0;
            wlen_reg  <= '0;
            abort_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            first_reg <= first_next;
            col_reg   <= col_next;
            start_reg <= start_next;
            word_reg  <= word_next;
            wlen_reg  <= wlen_next;
            abort_reg <= abort_next;
        end
    end

endmodule

// ----- rtl/blt_out_fifo.sv -----
module blt_out_fifo
    import blt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    output logic  room,
    output logic  valid,
    input  logic  ready,
    output res_t  head
);

    res_t       mem [4];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] cnt_reg;
    logic       pop;

    assign pop   = valid && ready;
    assign valid = (cnt_reg != 3'd0);
    assign room  = (cnt_reg <= 3'd2);
    assign head  = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_reg] <= push.r0;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_reg + 2'd1] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_reg + push.count;
            rd_reg  <= rd_reg + {1'b0, pop};
            cnt_reg <= cnt_reg + {1'b0, push.count} - {2'b00, pop};
        end
    end

endmodule

// ----- rtl/basic_line_tokenizer.sv -----
// channel   dir  payload                                                     role
// tok_in    in   source_byte[8], line_end                                    one char or end of line
// tok_out   out  token_kind[7], start_column[9], source_length[9],
//                error_code[2], run_last                                     one token per request
//
// One input request per cycle while tok_in.ready is high; the scanner state updates in the accept
// cycle and the 0..2 tokens it closes land in a 4-entry result queue, visible the next cycle.
// Sustained rate is set by the output port: one token per cycle while tok_out.ready is high.
// tok_in.ready drops while fewer than two queue slots are free.
// rst_n clears scanner state and queue at once; no clearing pass.
module basic_line_tokenizer
    import blt_pkg::*;
(
    input logic           clk,
    input logic           rst_n,
    blt_in_if.sink        tok_in,
    blt_out_if.source     tok_out
);

    push_t push;
    res_t  head;
    logic  room;
    logic  accept;

    assign tok_in.ready = room;
    assign accept       = tok_in.valid && room;

    // per-character lexer: mode register plus keyword compare
    blt_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .c        (tok_in.source_byte),
        .line_end (tok_in.line_end),
        .push     (push)
    );

    // result queue decouples the two sides
    blt_out_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .valid (tok_out.valid),
        .ready (tok_out.ready),
        .head  (head)
    );

    assign tok_out.token_kind    = head.kind;
    assign tok_out.start_column  = head.col;
    assign tok_out.source_length = head.len;
    assign tok_out.error_code    = head.err;
    assign tok_out.run_last      = head.last;

endmodule

// ----- rtl/blt_checker.sv -----
module blt_checker
    import blt_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] token_kind,
    input logic [8:0] start_column,
    input logic [8:0] source_length,
    input logic [1:0] error_code,
    input logic       run_last
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_kind) && $stable(start_column))
        else $error("stalled token changed");

    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error_code != E_NONE) |->
            (token_kind == K_EOL) && (source_length == 9'd0) && run_last)
        else $error("malformed error token");

    a_eol_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (token_kind == K_EOL) |-> run_last && (source_length == 9'd0))
        else $error("end of line not last");

    a_col: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (start_column != 9'd0) && (token_kind <= K_LAST))
        else $error("bad column or kind");

endmodule

bind basic_line_tokenizer blt_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (tok_out.valid),
    .out_ready     (tok_out.ready),
    .token_kind    (tok_out.token_kind),
    .start_column  (tok_out.start_column),
    .source_length (tok_out.source_length),
    .error_code    (tok_out.error_code),
    .run_last      (tok_out.run_last)
);
